### sv/pcbp_pkg.sv
// Shared types and constants for the prefix-code bit packer.
package pcbp_pkg;

  // Request codes carried in the mode field
  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_SYMBOL = 2'd1;
  localparam logic [1:0] MODE_END    = 2'd2;
  localparam logic [1:0] MODE_RSVD   = 2'd3;

  // Symbol whose code closes a message
  localparam logic [7:0] END_SYMBOL = 8'h04;

  // Job queue between the lookup front and the packing back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [1:0]  mode;
    logic [4:0]  entry_index;
    logic [7:0]  entry_symbol;
    logic [31:0] entry_code;
    logic [5:0]  entry_length;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } out_item_t;

  // One packing job: a right-aligned code, its length, and the flush flag
  typedef struct packed {
    logic        is_end;
    logic [5:0]  length;
    logic [31:0] code;
  } job_t;

endpackage

### sv/pcbp_queue.sv
// Short job queue that decouples table lookup from bit packing.
module pcbp_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  output logic            full,
  input  pcbp_pkg::job_t  job_in,
  input  logic            pop,
  output logic            empty,
  output pcbp_pkg::job_t  job_out
);
  import pcbp_pkg::*;

  job_t                slots_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r;
  logic [QUEUE_AW-1:0] rd_ptr_r;
  logic [QUEUE_CW-1:0] count_r;
  logic                do_push;
  logic                do_pop;

  assign full    = (count_r == QUEUE_CW'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign job_out = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QUEUE_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QUEUE_AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + QUEUE_CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - QUEUE_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= job_in;
    end
  end

endmodule

### sv/pcbp_front.sv
// Request intake: table writes, first-match symbol lookup and job issue.
module pcbp_front #(
  parameter int TABLE_ENTRIES = 32,
  parameter int MAX_CODE_LEN  = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  pcbp_pkg::in_item_t in_item,
  output logic               q_push,
  input  logic               q_full,
  output pcbp_pkg::job_t     q_job
);
  import pcbp_pkg::*;

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int LW = $clog2(MAX_CODE_LEN + 1);
  localparam int CW = MAX_CODE_LEN;

  typedef enum logic [1:0] {ST_IDLE, ST_FIND, ST_READ, ST_PUSH} state_t;

  state_t                   state_r;
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [7:0]               sym_r [TABLE_ENTRIES];
  logic [LW+CW-1:0]         code_mem_r [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] match_r;
  logic                     is_end_r;
  logic                     hit_r;
  logic [IW-1:0]            idx_r;
  logic [LW+CW-1:0]         rd_word_r;
  logic                     rd_valid_r;

  logic [7:0]               key;
  logic [TABLE_ENTRIES-1:0] match_nxt;
  logic [IW-1:0]            find_idx;
  logic                     find_hit;
  logic [IW-1:0]            ld_idx;
  logic                     ld_ok;
  logic [LW-1:0]            ld_len;
  logic                     accept;
  logic                     load_we;

  assign in_full = (state_r != ST_IDLE);
  assign accept  = in_push && !in_full;
  assign key     = (in_item.mode == MODE_END) ? END_SYMBOL : in_item.data_byte;
  assign ld_idx  = IW'(in_item.entry_index);
  assign ld_ok   = (32'(in_item.entry_index) < TABLE_ENTRIES);
  assign ld_len  = (32'(in_item.entry_length) > MAX_CODE_LEN) ? LW'(MAX_CODE_LEN)
                                                              : LW'(in_item.entry_length);
  assign load_we = accept && (in_item.mode == MODE_LOAD) && ld_ok;

  // An unwritten entry reads as symbol zero
  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      match_nxt[i] = valid_r[i] ? (sym_r[i] == key) : (key == 8'h00);
    end
  end

  // Lowest matching entry wins
  always_comb begin
    find_idx = '0;
    find_hit = 1'b0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        find_idx = IW'(i);
        find_hit = 1'b1;
      end
    end
  end

  assign q_push       = (state_r == ST_PUSH) && !q_full && (hit_r || is_end_r);
  assign q_job.is_end = is_end_r;
  assign q_job.length = (hit_r && rd_valid_r) ? 6'(rd_word_r[LW+CW-1:CW]) : 6'd0;
  assign q_job.code   = 32'(rd_word_r[CW-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            unique case (in_item.mode)
              MODE_LOAD: begin
                if (ld_ok) begin
                  valid_r[ld_idx] <= 1'b1;
                end
              end
              MODE_SYMBOL, MODE_END: begin
                match_r  <= match_nxt;
                is_end_r <= (in_item.mode == MODE_END);
                state_r  <= ST_FIND;
              end
              MODE_RSVD: begin
              end
              default: begin
              end
            endcase
          end
        end
        ST_FIND: begin
          idx_r   <= find_idx;
          hit_r   <= find_hit;
          state_r <= ST_READ;
        end
        ST_READ: begin
          state_r <= ST_PUSH;
        end
        ST_PUSH: begin
          // drop unmatched symbols; hold until the queue has room
          if (!(hit_r || is_end_r) || !q_full) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_we) begin
      sym_r[ld_idx]      <= in_item.entry_symbol;
      code_mem_r[ld_idx] <= {ld_len, in_item.entry_code[CW-1:0]};
    end
    rd_word_r  <= code_mem_r[idx_r];
    rd_valid_r <= valid_r[idx_r];
  end

endmodule

### sv/pcbp_back.sv
// Bit packer: shifts job codes out MSB first, emits full bytes and pads the last partial byte of an end job.
module pcbp_back #(
  parameter int MAX_CODE_LEN = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  pcbp_pkg::job_t      q_job,
  output logic                q_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output pcbp_pkg::out_item_t out_item
);
  import pcbp_pkg::*;

  localparam int LW = $clog2(MAX_CODE_LEN + 1);
  localparam int CW = MAX_CODE_LEN;
  localparam int SW = ((LW > 3) ? LW : 3) + 1;

  typedef enum logic {B_IDLE, B_RUN} state_t;

  state_t        state_r;
  logic [CW-1:0] code_r;
  logic [LW-1:0] rem_r;
  logic [6:0]    pbits_r;
  logic [2:0]    pcount_r;
  logic          end_r;
  logic          out_valid_r;
  out_item_t     out_item_r;

  logic [CW+7:0] ext;
  logic [14:0]   win;
  logic [SW-1:0] avail;
  logic [3:0]    take;
  logic [7:0]    full_byte;
  logic [7:0]    flush_byte;
  logic [6:0]    absorb_bits;
  logic          can_emit;
  logic [LW-1:0] shamt;

  assign ext         = {code_r, 8'h00};
  assign win         = {pbits_r, ext[CW+7 -: 8]};
  assign avail       = SW'(pcount_r) + SW'(rem_r);
  assign take        = 4'd8 - {1'b0, pcount_r};
  assign full_byte   = 8'(win >> pcount_r);
  assign flush_byte  = 8'({pbits_r, 8'h00} >> pcount_r);
  assign absorb_bits = 7'(win >> (4'd8 - 4'(rem_r)));
  assign can_emit    = !out_valid_r || out_pop;
  assign q_pop       = (state_r == B_IDLE) && !q_empty;
  assign shamt       = LW'(CW) - LW'(q_job.length);
  assign out_empty   = !out_valid_r;
  assign out_item    = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      pcount_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_pop && out_valid_r) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            code_r  <= q_job.code[CW-1:0] << shamt;
            rem_r   <= LW'(q_job.length);
            end_r   <= q_job.is_end;
            state_r <= B_RUN;
          end
        end
        B_RUN: begin
          priority if (avail >= SW'(8)) begin
            if (can_emit) begin
              out_item_r.out_byte  <= full_byte;
              out_item_r.last_byte <= end_r && (SW'(rem_r) == SW'(take));
              out_valid_r          <= 1'b1;
              code_r               <= code_r << take;
              rem_r                <= rem_r - LW'(take);
              pcount_r             <= '0;
            end
          end else if (rem_r != '0) begin
            pbits_r  <= absorb_bits;
            pcount_r <= 3'(pcount_r + 3'(rem_r));
            rem_r    <= '0;
          end else if (end_r && (pcount_r != '0)) begin
            if (can_emit) begin
              out_item_r.out_byte  <= flush_byte;
              out_item_r.last_byte <= 1'b1;
              out_valid_r          <= 1'b1;
              pcount_r             <= '0;
              state_r              <= B_IDLE;
            end
          end else begin
            state_r <= B_IDLE;
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

endmodule

### sv/prefix_code_bit_packer.sv
// Flow: a load request is written at its accepting edge and the next may follow at once; a
// symbol or end request holds in_full through the find, read and push states (longer while the
// queue is full), and with the packer idle its job then passes the queue before its first byte.
// Lookup handles one symbol or end request at a time; the packer takes a job, emits each full
// byte, parks any leftover bits and then flushes or goes idle, each as its own step. The
// two-entry queue absorbs the gap, and a held pop stalls the packer for as long as it is held.
// Reset (rst_n low, synchronous): table reads as all-zero entries, packer and queue emptied.
module prefix_code_bit_packer #(
  parameter int TABLE_ENTRIES = 32,
  parameter int MAX_CODE_LEN  = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  pcbp_pkg::in_item_t  in_item,
  output logic                out_empty,
  input  logic                out_pop,
  output pcbp_pkg::out_item_t out_item
);
  import pcbp_pkg::*;

  // Front to queue
  logic q_push;
  logic q_full;
  job_t q_in_job;

  // Queue to back
  logic q_pop;
  logic q_empty;
  job_t q_out_job;

  // The front takes each request. Loads write the symbol flops and the code
  // memory at once and leave the front free next cycle. Symbol and end
  // requests compare the key against every entry, register the match row,
  // pick the lowest hit, read the code memory and then issue one job.
  // Unmatched symbols issue nothing; an end request always issues a job so
  // the packer flushes even when no end code exists.
  pcbp_front #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .MAX_CODE_LEN  (MAX_CODE_LEN)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_item (in_item),
    .q_push  (q_push),
    .q_full  (q_full),
    .q_job   (q_in_job)
  );

  // A short queue lets lookup of the next request run while the packer
  // is still draining bytes, or while the consumer holds off pop.
  pcbp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .full    (q_full),
    .job_in  (q_in_job),
    .pop     (q_pop),
    .empty   (q_empty),
    .job_out (q_out_job)
  );

  // The back left-aligns each code and advances it a byte at a time into
  // a single output register; the final byte of an end request is marked
  // last, whether it is a full byte or the zero-padded remainder.
  pcbp_back #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_job     (q_out_job),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

### bench/prefix_code_bit_packer_test.sv
// Self-checking bench for the prefix-code bit packer: directed requests, then random traffic.
`timescale 1ns / 1ps

module prefix_code_bit_packer_test;
  import pcbp_pkg::*;

  localparam int ENTRIES  = 32;
  localparam int CODE_MAX = 32;

  // Mirror of the encoder: its own code table and byte packer. It turns every
  // accepted request into the bytes the block must emit, oldest first.
  class byte_stream_checker;
    logic [7:0]  sym_tbl[ENTRIES];
    logic [31:0] code_tbl[ENTRIES];
    logic [5:0]  len_tbl[ENTRIES];
    logic [7:0]  acc_bits;
    int          acc_cnt;
    out_item_t   expected_bytes[$];
    int          mismatches;

    function new();
      for (int i = 0; i < ENTRIES; i++) begin
        sym_tbl[i]  = '0;
        code_tbl[i] = '0;
        len_tbl[i]  = '0;
      end
      acc_bits   = '0;
      acc_cnt    = 0;
      mismatches = 0;
    endfunction

    // First entry holding the symbol, or -1
    function int lookup(logic [7:0] sym);
      for (int i = 0; i < ENTRIES; i++)
        if (sym_tbl[i] == sym) return i;
      return -1;
    endfunction

    // Shift an entry's code in, MSB first; queue each byte that fills
    function void pack_code(int e, ref int emitted);
      out_item_t b;
      for (int j = int'(len_tbl[e]) - 1; j >= 0; j--) begin
        acc_bits = {acc_bits[6:0], code_tbl[e][j]};
        acc_cnt++;
        if (acc_cnt == 8) begin
          b.out_byte  = acc_bits;
          b.last_byte = 1'b0;
          expected_bytes.push_back(b);
          emitted++;
          acc_bits = '0;
          acc_cnt  = 0;
        end
      end
    endfunction

    function void note_request(in_item_t req);
      int        e;
      int        emitted;
      out_item_t b;
      emitted = 0;
      case (req.mode)
        MODE_LOAD: begin
          sym_tbl[req.entry_index]  = req.entry_symbol;
          code_tbl[req.entry_index] = req.entry_code;
          len_tbl[req.entry_index]  = (req.entry_length > CODE_MAX) ? 6'(CODE_MAX)
                                                                     : req.entry_length;
        end
        MODE_SYMBOL: begin
          e = lookup(req.data_byte);
          if (e >= 0) pack_code(e, emitted);
        end
        MODE_END: begin
          e = lookup(END_SYMBOL);
          if (e >= 0) pack_code(e, emitted);
          if (acc_cnt > 0) begin
            b.out_byte  = acc_bits << (8 - acc_cnt);
            b.last_byte = 1'b0;
            expected_bytes.push_back(b);
            emitted++;
          end
          if (emitted > 0) expected_bytes[expected_bytes.size() - 1].last_byte = 1'b1;
          acc_bits = '0;
          acc_cnt  = 0;
        end
        default: ;
      endcase
    endfunction

    function void check_byte(out_item_t got);
      out_item_t want;
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected byte %h last %b", $time, got.out_byte, got.last_byte);
        mismatches++;
        return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $display("%0t: out_byte expected %h actual %h", $time, want.out_byte, got.out_byte);
        mismatches++;
      end
      if (got.last_byte !== want.last_byte) begin
        $display("%0t: last_byte expected %b actual %b", $time, want.last_byte, got.last_byte);
        mismatches++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_push = 1'b0;
  logic      in_full;
  in_item_t  in_item = '0;
  logic      out_empty;
  logic      out_pop = 1'b0;
  out_item_t out_item;

  byte_stream_checker sb = new();
  bit calm = 1'b0;          // when set, neither side idles
  int pop_hold = 0;
  int requests_sent = 0;    // every request taken, directed and noise included

  prefix_code_bit_packer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_item (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle length: mostly none or short, now and then a long gap
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: values read here are the ones from before the edge, so a byte
  // counts as taken exactly when pop was high and empty low going into it.
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) sb.check_byte(out_item);
    if (pop_hold > 0) begin
      pop_hold <= pop_hold - 1;
      out_pop  <= 1'b0;
    end else begin
      pop_hold <= idle_cycles();
      out_pop  <= 1'b1;
    end
  end

  // Offer one request after an optional gap and hold it until taken. Push is
  // only lowered when a gap follows, so back-to-back requests keep it high.
  task automatic send_request(input in_item_t req);
    int hold;
    hold = idle_cycles();
    if (hold > 0) begin
      in_push <= 1'b0;
      repeat (hold) @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= req;
    do @(posedge clk); while (in_full);
    sb.note_request(req);
    requests_sent++;
  endtask

  task automatic send_load(input logic [4:0] idx, input logic [7:0] sym,
                           input logic [31:0] code, input logic [5:0] len);
    in_item_t req;
    req              = '0;
    req.mode         = MODE_LOAD;
    req.entry_index  = idx;
    req.entry_symbol = sym;
    req.entry_code   = code;
    req.entry_length = len;
    send_request(req);
  endtask

  task automatic send_op(input logic [1:0] mode, input logic [7:0] data);
    in_item_t req;
    req           = '0;
    req.mode      = mode;
    req.data_byte = data;
    send_request(req);
  endtask

  // Fill every field with noise, then set what the chosen request needs
  function automatic in_item_t scrambled_request();
    in_item_t req;
    req.mode         = 2'($urandom_range(0, 3));
    req.entry_index  = 5'($urandom_range(0, 31));
    req.entry_symbol = 8'($urandom_range(0, 255));
    req.entry_code   = $urandom;
    req.entry_length = 6'($urandom_range(0, 63));
    req.data_byte    = 8'($urandom_range(0, 255));
    return req;
  endfunction

  task automatic random_traffic(input int target);
    in_item_t req;
    int       r;
    bit       paused;
    paused = 1'b0;
    while (requests_sent < target) begin
      // Switch between gappy and gap-free stretches now and then
      if ($urandom_range(0, 39) == 0) calm = ~calm;
      // Once, stop offering until the packer has drained completely
      if (!paused && requests_sent >= target / 2) begin
        paused = 1'b1;
        in_push <= 1'b0;
        do @(posedge clk); while (sb.expected_bytes.size() != 0);
      end
      req = scrambled_request();
      r   = $urandom_range(0, 99);
      if (r < 12) begin
        req.mode = MODE_LOAD;
        r = $urandom_range(0, 9);
        if (r < 7) req.entry_length = 6'($urandom_range(1, 12));
        else if (r < 9) req.entry_length = 6'($urandom_range(13, CODE_MAX));
      end else if (r < 80) begin
        // Pick a byte that is in the table so most symbols emit bits
        req.mode      = MODE_SYMBOL;
        req.data_byte = sb.sym_tbl[$urandom_range(0, ENTRIES - 1)];
      end else if (r < 90) begin
        req.mode = MODE_END;
      end else if (r < 95) begin
        req.mode = MODE_RSVD;
      end else begin
        // Arbitrary byte: may or may not hit an entry
        req.mode = MODE_SYMBOL;
      end
      send_request(req);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fresh table: 0x00 hits entry 0 with no bits, flush has nothing to send
    send_op(MODE_SYMBOL, 8'h00);
    send_op(MODE_END, 8'h00);
    begin
      in_item_t junk;
      junk      = '1;
      junk.mode = MODE_RSVD;
      send_request(junk);
    end
    // Widest code of all ones in the top entry
    send_load(5'd31, 8'hFF, 32'hFFFF_FFFF, 6'd32);
    send_op(MODE_SYMBOL, 8'hFF);
    // Overlong length clamps to the maximum; all-zero code
    send_load(5'd0, 8'h00, 32'h0000_0000, 6'd63);
    send_op(MODE_SYMBOL, 8'h00);
    // Duplicate symbol: the lower entry must win
    send_load(5'd1, 8'h41, 32'h0000_0005, 6'd3);
    send_load(5'd2, 8'h41, 32'h0000_0007, 6'd3);
    // Zero-length entry matches but adds nothing
    send_load(5'd3, 8'h42, 32'h0000_ABCD, 6'd0);
    send_op(MODE_SYMBOL, 8'h42);
    send_op(MODE_SYMBOL, 8'h41);
    send_op(MODE_SYMBOL, 8'h99);          // no entry: ignored
    send_op(MODE_END, 8'h00);             // no end code: pad the partial byte
    // Seven pending bits plus a 32-bit end code: the five-byte flush
    send_load(5'd4, END_SYMBOL, 32'h1234_5678, 6'd32);
    send_load(5'd5, 8'h7F, 32'h0000_007F, 6'd7);
    send_op(MODE_SYMBOL, 8'h7F);
    send_op(MODE_END, 8'h00);
    // Flush that lands on a byte boundary: last flag on a full byte
    send_load(5'd4, END_SYMBOL, 32'h0000_00C3, 6'd8);
    send_op(MODE_END, 8'h00);
    send_op(MODE_SYMBOL, 8'h41);
    send_load(5'd4, END_SYMBOL, 32'h0000_0015, 6'd5);
    send_op(MODE_END, 8'h00);
    send_op(MODE_SYMBOL, 8'hFF);

    random_traffic(450);

    // Drain with the result side always ready, then allow stray bytes to show
    in_push <= 1'b0;
    calm = 1'b1;
    do @(posedge clk); while (sb.expected_bytes.size() != 0);
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
